// ----- rtl/preemptive_priority_schedule_sim_top_assert.svh -----
// Assertion macros for the preemptive priority scheduler top level
`ifndef PREEMPTIVE_PRIORITY_SCHEDULE_SIM_TOP_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULE_SIM_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PPSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PPSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ppss_pkg.sv -----
// Shared widths, record types and control structs for the scheduler
package ppss_pkg;

  localparam int ARR_W  = 10;
  localparam int BUR_W  = 8;
  localparam int PRI_W  = 8;
  localparam int PN_W   = 5;
  localparam int TIME_W = 13;
  localparam int SUM_W  = 17;

  typedef struct packed {
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
    logic [BUR_W-1:0] rem;
  } rec_t;

  typedef struct packed {
    logic [PN_W-1:0]   process_number;
    logic [ARR_W-1:0]  arrival_echo;
    logic [BUR_W-1:0]  burst_echo;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] average_waiting;
    logic [TIME_W-1:0] average_turnaround;
    logic              last_result;
  } res_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan;
    logic exec;
    logic div_start;
    logic div_sel;
    logic cap_avg_w;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic trigger;
    logic empty;
    logic scan_done;
    logic completes;
    logic final_done;
    logic out_busy;
    logic div_done;
  } stat_t;

endpackage

// ----- rtl/ppss_in_if.sv -----
// Process record channel: valid, ready and one process per beat
interface ppss_in_if;
  import ppss_pkg::*;

  logic             valid;
  logic             ready;
  logic [ARR_W-1:0] arrival_time;
  logic [BUR_W-1:0] burst_time;
  logic [PRI_W-1:0] priority_req;
  logic             last_process;

  modport source (output valid, output arrival_time, output burst_time,
                  output priority_req, output last_process, input ready);
  modport sink (input valid, input arrival_time, input burst_time,
                input priority_req, input last_process, output ready);
endinterface

// ----- rtl/ppss_out_if.sv -----
// Completion record channel: valid, ready and one completion per beat
interface ppss_out_if;
  import ppss_pkg::*;

  logic              valid;
  logic              ready;
  logic [PN_W-1:0]   process_number;
  logic [ARR_W-1:0]  arrival_echo;
  logic [BUR_W-1:0]  burst_echo;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [TIME_W-1:0] waiting_time;
  logic [TIME_W-1:0] average_waiting;
  logic [TIME_W-1:0] average_turnaround;
  logic              last_result;

  modport source (output valid, output process_number, output arrival_echo,
                  output burst_echo, output completion_time, output turnaround_time,
                  output waiting_time, output average_waiting,
                  output average_turnaround, output last_result, input ready);
  modport sink (input valid, input process_number, input arrival_echo,
                input burst_echo, input completion_time, input turnaround_time,
                input waiting_time, input average_waiting,
                input average_turnaround, input last_result, output ready);
endinterface

// ----- rtl/ppss_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle
module ppss_divider #(
  parameter int DD_W = 17,
  parameter int DV_W = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DD_W-1:0] dividend,
  input  logic [DV_W-1:0] divisor,
  output logic [DD_W-1:0] quotient,
  output logic            done
);
  localparam int CW = $clog2(DD_W + 1);

  logic [DV_W-1:0] rem;
  logic [DD_W-1:0] quo;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [DV_W:0]   shifted;
  logic [DV_W:0]   diff;
  logic            ge;

  assign shifted  = {rem, quo[DD_W-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign diff     = shifted - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DV_W-1:0] : shifted[DV_W-1:0];
      quo <= {quo[DD_W-2:0], ge};
    end
  end
endmodule

// ----- rtl/ppss_datapath.sv -----
// Process table, ready scan, tick counter, sums and completion register
module ppss_datapath #(
  parameter int MAX_PROCESSES = 16,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ppss_pkg::cmd_t         cmd,
  input  logic [ppss_pkg::ARR_W-1:0] in_arrival,
  input  logic [ppss_pkg::BUR_W-1:0] in_burst,
  input  logic [ppss_pkg::PRI_W-1:0] in_priority,
  input  logic                   in_last,
  input  logic                   out_ready,
  output ppss_pkg::stat_t        stat,
  output ppss_pkg::res_t         res,
  output logic                   out_valid
);
  import ppss_pkg::*;

  rec_t              mem [MAX_PROCESSES];
  rec_t              rd_data;
  rec_t              best_rec;
  rec_t              wr_rec;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CNT_W-1:0]  loaded_count;
  logic [CNT_W-1:0]  finished_count;
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  fin_next;
  logic [TIME_W-1:0] tick;
  logic [TIME_W-1:0] tick_inc;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] wt;
  logic [TIME_W-1:0] avg_w;
  logic [SUM_W-1:0]  wsum;
  logic [SUM_W-1:0]  tsum;
  logic [SUM_W-1:0]  dividend;
  logic [SUM_W-1:0]  quotient;
  logic              div_done;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_idx;
  logic              best_valid;
  logic [IDX_W-1:0]  best_idx;
  logic              load_ok;
  logic              cand_ok;
  logic              cand_better;
  logic              completes;
  logic              final_done;

  assign load_ok  = cmd.load && (in_burst != '0) &&
                    (loaded_count < CNT_W'(MAX_PROCESSES));
  assign tick_inc = tick + TIME_W'(1);
  assign tat      = tick_inc - TIME_W'(best_rec.arr);
  assign wt       = tat - TIME_W'(best_rec.burst);
  assign fin_next = finished_count + CNT_W'(1);
  assign completes  = best_valid && (best_rec.rem == BUR_W'(1));
  assign final_done = completes && (fin_next == loaded_count);

  assign cand_ok = (rd_data.rem != '0) && (TIME_W'(rd_data.arr) <= tick);
  assign cand_better = cand_ok && (!best_valid || (rd_data.prio < best_rec.prio) ||
                       ((rd_data.prio == best_rec.prio) && (rd_data.arr < best_rec.arr)));

  always_comb begin
    wr_en   = load_ok || (cmd.exec && best_valid);
    wr_addr = best_idx;
    wr_rec  = best_rec;
    wr_rec.rem = best_rec.rem - BUR_W'(1);
    if (cmd.load) begin
      wr_addr = loaded_count[IDX_W-1:0];
      wr_rec  = '{arr: in_arrival, burst: in_burst, prio: in_priority, rem: in_burst};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    rd_data <= mem[scan_idx[IDX_W-1:0]];
  end

  assign dividend = cmd.div_sel ? tsum : wsum;

  ppss_divider #(
    .DD_W (SUM_W),
    .DV_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (loaded_count),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count   <= '0;
      finished_count <= '0;
      tick           <= '0;
      wsum           <= '0;
      tsum           <= '0;
      scan_idx       <= '0;
      rd_pend        <= 1'b0;
      best_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_ok) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        scan_idx   <= '0;
        rd_pend    <= 1'b0;
        best_valid <= 1'b0;
      end else if (cmd.scan) begin
        rd_pend <= scan_idx < loaded_count;
        if (scan_idx < loaded_count) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (rd_pend && cand_better) begin
          best_valid <= 1'b1;
        end
      end
      if (cmd.exec) begin
        tick <= tick_inc;
        if (completes) begin
          finished_count <= fin_next;
          wsum <= wsum + SUM_W'(wt);
          tsum <= tsum + SUM_W'(tat);
          if (!final_done) begin
            out_valid <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        out_valid      <= 1'b1;
        loaded_count   <= '0;
        finished_count <= '0;
        tick           <= '0;
        wsum           <= '0;
        tsum           <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx <= scan_idx[IDX_W-1:0];
      if (rd_pend && cand_better) begin
        best_idx <= rd_idx;
        best_rec <= rd_data;
      end
    end
    if (cmd.exec) begin
      best_rec.rem <= best_rec.rem - BUR_W'(1);
    end
    if (cmd.exec && completes) begin
      res.process_number     <= PN_W'(best_idx) + PN_W'(1);
      res.arrival_echo       <= best_rec.arr;
      res.burst_echo         <= best_rec.burst;
      res.completion_time    <= tick_inc;
      res.turnaround_time    <= tat;
      res.waiting_time       <= wt;
      res.average_waiting    <= '0;
      res.average_turnaround <= '0;
      res.last_result        <= 1'b0;
    end
    if (cmd.cap_avg_w) begin
      avg_w <= quotient[TIME_W-1:0];
    end
    if (cmd.finish) begin
      res.average_waiting    <= avg_w;
      res.average_turnaround <= quotient[TIME_W-1:0];
      res.last_result        <= 1'b1;
    end
  end

  always_comb begin
    stat.trigger    = in_last ||
                      ((in_burst != '0) && (loaded_count == CNT_W'(MAX_PROCESSES - 1)));
    stat.empty      = (in_burst == '0) && (loaded_count == '0);
    stat.scan_done  = (scan_idx == loaded_count) && !rd_pend;
    stat.completes  = completes;
    stat.final_done = final_done;
    stat.out_busy   = out_valid;
    stat.div_done   = div_done;
  end
endmodule

// ----- rtl/ppss_ctrl.sv -----
// Sequencer for loading, per-tick scan and step, and the final averages
module ppss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ppss_pkg::stat_t stat,
  output ppss_pkg::cmd_t  cmd
);
  import ppss_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PREP     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_EXEC     = 3'd3;
  localparam logic [2:0] S_DIVW_GO  = 3'd4;
  localparam logic [2:0] S_DIVW_RUN = 3'd5;
  localparam logic [2:0] S_DIVT_GO  = 3'd6;
  localparam logic [2:0] S_DIVT_RUN = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && stat.trigger && !stat.empty) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (!stat.out_busy) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.final_done ? S_DIVW_GO : S_PREP;
      end
      S_DIVW_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW_RUN;
      end
      S_DIVW_RUN: begin
        if (stat.div_done) begin
          cmd.cap_avg_w = 1'b1;
          state_next    = S_DIVT_GO;
        end
      end
      S_DIVT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = S_DIVT_RUN;
      end
      S_DIVT_RUN: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// ----- rtl/preemptive_priority_schedule_sim_top.sv -----
// Preemptive priority scheduler: loads a process set, then simulates it tick by tick.
// Loading takes one process per cycle while the block is idle. The beat that carries
// last_process, or the one that fills the table, starts the simulation, and no further
// beat is taken until the final completion record has been built. Each simulated tick
// scans every loaded entry of the single-port process table, so its length depends on
// the loaded count and not on MAX_PROCESSES; a completion waits for the result register
// to drain before the next tick starts. The two averages of the final record then share
// one bit-serial divider (one quotient bit per cycle over the 17-bit sums).
`include "preemptive_priority_schedule_sim_top_assert.svh"
module preemptive_priority_schedule_sim_top #(
  parameter int MAX_PROCESSES = 16
) (
  input logic        clk,
  input logic        rst,
  ppss_in_if.sink    load,
  ppss_out_if.source result
);
  import ppss_pkg::*;

  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  out_valid;
  logic  in_ready;

  ppss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (load.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppss_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .CNT_W         (CNT_W),
    .IDX_W         (IDX_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_arrival  (load.arrival_time),
    .in_burst    (load.burst_time),
    .in_priority (load.priority_req),
    .in_last     (load.last_process),
    .out_ready   (result.ready),
    .stat        (stat),
    .res         (res),
    .out_valid   (out_valid)
  );

  assign load.ready                = in_ready;
  assign result.valid              = out_valid;
  assign result.process_number     = res.process_number;
  assign result.arrival_echo       = res.arrival_echo;
  assign result.burst_echo         = res.burst_echo;
  assign result.completion_time    = res.completion_time;
  assign result.turnaround_time    = res.turnaround_time;
  assign result.waiting_time       = res.waiting_time;
  assign result.average_waiting    = res.average_waiting;
  assign result.average_turnaround = res.average_turnaround;
  assign result.last_result        = res.last_result;

  `PPSS_ASSERT_NOW(a_exec_after_scan, cmd.exec, $past(stat.scan_done), "tick step without finished scan")
  `PPSS_ASSERT_NOW(a_no_overwrite, cmd.exec && stat.completes, !stat.out_busy, "completion while result pending")
  `PPSS_ASSERT_NEXT(a_final_record, cmd.finish, result.valid && result.last_result, "final record not presented")
endmodule
